/* hw/rtl/ldef_pkg.sv */
// types and constants shared by the luma deblocking edge filter
// used by ldef_clip, luma_deblocking_edge_filter and ldef_checker; depends on nothing
package ldef_pkg;

    localparam logic [2:0] BS_NONE   = 3'd0;
    localparam logic [2:0] BS_STRONG = 3'd4;

    // strong filter step bound is (alpha >> 2) + STEP_BOUND_BIAS
    localparam logic [7:0] STEP_BOUND_BIAS = 8'd2;

    localparam int unsigned S_DATA_W = 88;
    localparam int unsigned M_DATA_W = 56;

    // decision flags and samples after the activity test
    typedef struct packed {
        logic [7:0] p3;
        logic [7:0] p2;
        logic [7:0] p1;
        logic [7:0] p0;
        logic [7:0] q0;
        logic [7:0] q1;
        logic [7:0] q2;
        logic [7:0] q3;
        logic       active;
        logic       strong_sel;
        logic       ap;
        logic       aq;
        logic       step_near;
        logic [4:0] tc0;
    } ldef_stage_a_t;

    // filter sums, before clipping and selection
    typedef struct packed {
        logic [7:0]        p2;
        logic [7:0]        p1;
        logic [7:0]        p0;
        logic [7:0]        q0;
        logic [7:0]        q1;
        logic [7:0]        q2;
        logic              active;
        logic              strong_sel;
        logic              ap;
        logic              aq;
        logic [4:0]        tc0;
        logic [5:0]        tc;
        logic [7:0]        sp2;
        logic [7:0]        sp1;
        logic [7:0]        sp0;
        logic [7:0]        sq0;
        logic [7:0]        sq1;
        logic [7:0]        sq2;
        logic signed [8:0] delta_raw;
        logic signed [9:0] p1_tap;
        logic signed [9:0] q1_tap;
    } ldef_stage_b_t;

    typedef struct packed {
        logic [7:0] p2;
        logic [7:0] p1;
        logic [7:0] p0;
        logic [7:0] q0;
        logic [7:0] q1;
        logic [7:0] q2;
        logic       filtered;
    } ldef_result_t;

endpackage

/* hw/rtl/luma_deblocking_edge_filter.sv */
// top level of the luma deblocking edge filter: three-stage pipeline with stall control
// depends on ldef_pkg and ldef_clip
//
// Usage: one request on the s_ channel carries one line of eight luma samples
// p3..p0 | q0..q3 across a block edge, with its boundary strength, alpha, beta
// and tc0. The m_ channel returns the six filtered samples p2..q2 and a flag
// that tells whether the edge was filtered. Every request gives exactly one
// result, in order.
// m_tvalid rises once the request has been registered through stages A, B
// and C: stage A runs the activity and flatness tests, stage B forms the
// filter sums, stage C clips, saturates and selects into the output
// register. While m_tready is high, a new request is taken every cycle.
// When the receiver holds m_tready low, each stage keeps its item while the
// stage behind it is full; bubbles still fill, so s_tready drops only once
// all three stages hold an item. s_tready is high whenever m_tvalid is low.
// A synchronous low aresetn empties the pipeline; no results are pending
// afterwards.
module luma_deblocking_edge_filter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // p3_in, p2_in, p1_in, p0_in, q0_in, q1_in, q2_in, q3_in (8 each),
    // strength (3), alpha_limit (8), beta_limit (8), clip_base (5)
    input  logic [ldef_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // p2_out, p1_out, p0_out, q0_out, q1_out, q2_out (8 each), was_filtered (1),
    // zero padding (7)
    output logic [ldef_pkg::M_DATA_W-1:0]  m_tdata
);

    // input fields
    logic [7:0] p3;
    logic [7:0] p2;
    logic [7:0] p1;
    logic [7:0] p0;
    logic [7:0] q0;
    logic [7:0] q1;
    logic [7:0] q2;
    logic [7:0] q3;
    logic [2:0] strength;
    logic [7:0] alpha_limit;
    logic [7:0] beta_limit;
    logic [4:0] clip_base;

    assign p3          = s_tdata[7:0];
    assign p2          = s_tdata[15:8];
    assign p1          = s_tdata[23:16];
    assign p0          = s_tdata[31:24];
    assign q0          = s_tdata[39:32];
    assign q1          = s_tdata[47:40];
    assign q2          = s_tdata[55:48];
    assign q3          = s_tdata[63:56];
    assign strength    = s_tdata[66:64];
    assign alpha_limit = s_tdata[74:67];
    assign beta_limit  = s_tdata[82:75];
    assign clip_base   = s_tdata[87:83];

    logic                    a_valid_reg;
    logic                    b_valid_reg;
    logic                    c_valid_reg;
    ldef_pkg::ldef_stage_a_t a_reg;
    ldef_pkg::ldef_stage_a_t a_next;
    ldef_pkg::ldef_stage_b_t b_reg;
    ldef_pkg::ldef_stage_b_t b_next;
    ldef_pkg::ldef_result_t  c_reg;
    ldef_pkg::ldef_result_t  c_next;

    logic a_ready;
    logic b_ready;
    logic c_ready;

    // a stage loads when it is empty or its item moves on
    assign c_ready  = !c_valid_reg || m_tready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;

    // stage A: activity and flatness tests
    logic [7:0] d_pq;
    logic [7:0] d_p10;
    logic [7:0] d_q10;
    logic [7:0] d_p20;
    logic [7:0] d_q20;
    logic [7:0] gap_bound;

    always_comb begin
        d_pq  = (p0 > q0) ? p0 - q0 : q0 - p0;
        d_p10 = (p1 > p0) ? p1 - p0 : p0 - p1;
        d_q10 = (q1 > q0) ? q1 - q0 : q0 - q1;
        d_p20 = (p2 > p0) ? p2 - p0 : p0 - p2;
        d_q20 = (q2 > q0) ? q2 - q0 : q0 - q2;
        gap_bound = {2'b0, alpha_limit[7:2]} + ldef_pkg::STEP_BOUND_BIAS;

        a_next.p3 = p3;
        a_next.p2 = p2;
        a_next.p1 = p1;
        a_next.p0 = p0;
        a_next.q0 = q0;
        a_next.q1 = q1;
        a_next.q2 = q2;
        a_next.q3 = q3;
        a_next.active = (strength != ldef_pkg::BS_NONE) && (d_pq < alpha_limit)
                        && (d_p10 < beta_limit) && (d_q10 < beta_limit);
        a_next.strong_sel = (strength == ldef_pkg::BS_STRONG);
        a_next.ap         = d_p20 < beta_limit;
        a_next.aq         = d_q20 < beta_limit;
        a_next.step_near  = d_pq < gap_bound;
        a_next.tc0        = clip_base;
    end

    // stage B: strong filter taps and normal filter raw terms
    logic [10:0]       full_p2;
    logic [9:0]        full_p1;
    logic [10:0]       full_p0;
    logic [9:0]        tap3_p0;
    logic [10:0]       full_q2;
    logic [9:0]        full_q1;
    logic [10:0]       full_q0;
    logic [9:0]        tap3_q0;
    logic [8:0]        avg_sum;
    logic [7:0]        avg;
    logic signed [11:0] d_sum;
    logic signed [10:0] p_tap;
    logic signed [10:0] q_tap;
    logic              p_full;
    logic              q_full;

    always_comb begin
        full_p2 = 11'({a_reg.p3, 1'b0}) + 11'({a_reg.p2, 1'b0}) + 11'(a_reg.p2)
                  + 11'(a_reg.p1) + 11'(a_reg.p0) + 11'(a_reg.q0) + 11'd4;
        full_p1 = 10'(a_reg.p2) + 10'(a_reg.p1) + 10'(a_reg.p0) + 10'(a_reg.q0) + 10'd2;
        full_p0 = 11'(a_reg.q1) + 11'({a_reg.p1, 1'b0}) + 11'({a_reg.p0, 1'b0})
                  + 11'({a_reg.q0, 1'b0}) + 11'(a_reg.p2) + 11'd4;
        tap3_p0 = 10'({a_reg.p1, 1'b0}) + 10'(a_reg.p0) + 10'(a_reg.q1) + 10'd2;
        full_q2 = 11'({a_reg.q3, 1'b0}) + 11'({a_reg.q2, 1'b0}) + 11'(a_reg.q2)
                  + 11'(a_reg.q1) + 11'(a_reg.p0) + 11'(a_reg.q0) + 11'd4;
        full_q1 = 10'(a_reg.q2) + 10'(a_reg.q1) + 10'(a_reg.p0) + 10'(a_reg.q0) + 10'd2;
        full_q0 = 11'(a_reg.p1) + 11'({a_reg.q1, 1'b0}) + 11'({a_reg.p0, 1'b0})
                  + 11'({a_reg.q0, 1'b0}) + 11'(a_reg.q2) + 11'd4;
        tap3_q0 = 10'({a_reg.q1, 1'b0}) + 10'(a_reg.q0) + 10'(a_reg.p1) + 10'd2;

        avg_sum = {1'b0, a_reg.p0} + {1'b0, a_reg.q0} + 9'd1;
        avg     = avg_sum[8:1];
        d_sum = $signed({2'b0, a_reg.q0, 2'b0}) - $signed({2'b0, a_reg.p0, 2'b0})
                + $signed({4'b0, a_reg.p1}) - $signed({4'b0, a_reg.q1}) + 12'sd4;
        p_tap = $signed({3'b0, a_reg.p2}) + $signed({3'b0, avg})
                - $signed({2'b0, a_reg.p1, 1'b0});
        q_tap = $signed({3'b0, a_reg.q2}) + $signed({3'b0, avg})
                - $signed({2'b0, a_reg.q1, 1'b0});

        p_full = a_reg.ap && a_reg.step_near;
        q_full = a_reg.aq && a_reg.step_near;

        b_next.p2         = a_reg.p2;
        b_next.p1         = a_reg.p1;
        b_next.p0         = a_reg.p0;
        b_next.q0         = a_reg.q0;
        b_next.q1         = a_reg.q1;
        b_next.q2         = a_reg.q2;
        b_next.active     = a_reg.active;
        b_next.strong_sel = a_reg.strong_sel;
        b_next.ap         = a_reg.ap;
        b_next.aq         = a_reg.aq;
        b_next.tc0        = a_reg.tc0;
        b_next.tc     = 6'(a_reg.tc0) + 6'(a_reg.ap) + 6'(a_reg.aq);
        b_next.sp2    = p_full ? full_p2[10:3] : a_reg.p2;
        b_next.sp1    = p_full ? full_p1[9:2]  : a_reg.p1;
        b_next.sp0    = p_full ? full_p0[10:3] : tap3_p0[9:2];
        b_next.sq2    = q_full ? full_q2[10:3] : a_reg.q2;
        b_next.sq1    = q_full ? full_q1[9:2]  : a_reg.q1;
        b_next.sq0    = q_full ? full_q0[10:3] : tap3_q0[9:2];
        // arithmetic shifts: floor toward minus infinity
        b_next.delta_raw = d_sum[11:3];
        b_next.p1_tap    = p_tap[10:1];
        b_next.q1_tap    = q_tap[10:1];
    end

    // stage C: clip, saturate and select
    ldef_clip u_clip (
        .stage_b (b_reg),
        .result  (c_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= s_tvalid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_reg <= a_next;
        end
        if (b_ready) begin
            b_reg <= b_next;
        end
        if (c_ready) begin
            c_reg <= c_next;
        end
    end

    assign m_tvalid = c_valid_reg;
    assign m_tdata  = {7'b0, c_reg.filtered, c_reg.q2, c_reg.q1, c_reg.q0,
                       c_reg.p0, c_reg.p1, c_reg.p2};

endmodule

/* hw/rtl/ldef_clip.sv */
// final stage of the edge filter: clipping, saturation and output selection
// depends on ldef_pkg
module ldef_clip (
    input  ldef_pkg::ldef_stage_b_t stage_b,
    output ldef_pkg::ldef_result_t  result
);

    function automatic logic signed [9:0] clip_sym(
        input logic signed [9:0] value,
        input logic [5:0]        bound
    );
        logic signed [9:0] hi;
        logic signed [9:0] lo;
        hi = $signed({4'b0, bound});
        lo = -hi;
        if (value > hi) begin
            return hi;
        end else if (value < lo) begin
            return lo;
        end
        return value;
    endfunction

    function automatic logic [7:0] sat8(input logic signed [9:0] value);
        if (value < 10'sd0) begin
            return 8'd0;
        end else if (value > 10'sd255) begin
            return 8'd255;
        end
        return value[7:0];
    endfunction

    logic signed [9:0] delta;
    logic signed [9:0] p1_adj;
    logic signed [9:0] q1_adj;
    logic [7:0]        np0;
    logic [7:0]        nq0;
    logic [7:0]        np1;
    logic [7:0]        nq1;

    always_comb begin
        delta  = clip_sym(10'(stage_b.delta_raw), stage_b.tc);
        p1_adj = clip_sym(stage_b.p1_tap, {1'b0, stage_b.tc0});
        q1_adj = clip_sym(stage_b.q1_tap, {1'b0, stage_b.tc0});
        np0 = sat8($signed({2'b0, stage_b.p0}) + delta);
        nq0 = sat8($signed({2'b0, stage_b.q0}) - delta);
        np1 = stage_b.ap ? sat8($signed({2'b0, stage_b.p1}) + p1_adj) : stage_b.p1;
        nq1 = stage_b.aq ? sat8($signed({2'b0, stage_b.q1}) + q1_adj) : stage_b.q1;

        result.filtered = stage_b.active;
        if (!stage_b.active) begin
            result.p2 = stage_b.p2;
            result.p1 = stage_b.p1;
            result.p0 = stage_b.p0;
            result.q0 = stage_b.q0;
            result.q1 = stage_b.q1;
            result.q2 = stage_b.q2;
        end else if (stage_b.strong_sel) begin
            result.p2 = stage_b.sp2;
            result.p1 = stage_b.sp1;
            result.p0 = stage_b.sp0;
            result.q0 = stage_b.sq0;
            result.q1 = stage_b.sq1;
            result.q2 = stage_b.sq2;
        end else begin
            result.p2 = stage_b.p2;
            result.p1 = np1;
            result.p0 = np0;
            result.q0 = nq0;
            result.q1 = nq1;
            result.q2 = stage_b.q2;
        end
    end

endmodule

/* hw/rtl/ldef_checker.sv */
// port-level checks for the luma deblocking edge filter, bound to the top level
// depends on ldef_pkg and luma_deblocking_edge_filter
module ldef_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [ldef_pkg::S_DATA_W-1:0]  s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ldef_pkg::M_DATA_W-1:0]  m_tdata
);

    // a stalled result holds still
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // no result pending right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // with the output stage empty the pipeline cannot be full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request refused with output stage empty");

    // padding above the filtered flag stays zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[ldef_pkg::M_DATA_W-1:49] == '0)
        else $error("nonzero padding in result");

    // an accepted request, registered through stages A, B and C, keeps the output stage occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##3 m_tvalid)
        else $error("result latency broken");

endmodule

bind luma_deblocking_edge_filter ldef_checker u_ldef_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
